// ----- hw/rtl/ucdc_pkg.sv -----
// ----------------------------------------------------------------------------
// ucdc_pkg
// Shared types, codes and descriptor tables of the CDC-ACM control responder.
// ----------------------------------------------------------------------------
package ucdc_pkg;

   localparam int unsigned MAX_PACKET = 64;

   localparam logic [2:0] CMD_BUS_RESET = 3'd0;
   localparam logic [2:0] CMD_SETUP     = 3'd1;
   localparam logic [2:0] CMD_OUT_DATA  = 3'd2;
   localparam logic [2:0] CMD_IN_DONE   = 3'd3;
   localparam logic [2:0] CMD_DATA_BYTE = 3'd4;

   localparam logic [2:0] ACT_DATA   = 3'd0;
   localparam logic [2:0] ACT_ZLP    = 3'd1;
   localparam logic [2:0] ACT_STALL  = 3'd2;
   localparam logic [2:0] ACT_ARM    = 3'd3;
   localparam logic [2:0] ACT_ADDR   = 3'd4;
   localparam logic [2:0] ACT_ENABLE = 3'd5;
   localparam logic [2:0] ACT_NONE   = 3'd6;

   localparam logic [1:0] REG_VENDOR_ID  = 2'd0;
   localparam logic [1:0] REG_PRODUCT_ID = 2'd1;
   localparam logic [1:0] REG_TOUCH_BAUD = 2'd2;

   localparam logic [1:0] KIND_STANDARD = 2'd0;
   localparam logic [1:0] KIND_CLASS    = 2'd1;

   localparam logic [7:0] REQ_GET_STATUS    = 8'h00;
   localparam logic [7:0] REQ_CLEAR_FEATURE = 8'h01;
   localparam logic [7:0] REQ_SET_ADDRESS   = 8'h05;
   localparam logic [7:0] REQ_GET_DESC      = 8'h06;
   localparam logic [7:0] REQ_GET_CONFIG    = 8'h08;
   localparam logic [7:0] REQ_SET_CONFIG    = 8'h09;
   localparam logic [7:0] REQ_GET_IFACE     = 8'h0A;
   localparam logic [7:0] REQ_SET_IFACE     = 8'h0B;
   localparam logic [7:0] REQ_SET_CODING    = 8'h20;
   localparam logic [7:0] REQ_GET_CODING    = 8'h21;
   localparam logic [7:0] REQ_LINE_STATE    = 8'h22;
   localparam logic [7:0] REQ_SEND_BREAK    = 8'h23;

   localparam logic [2:0] SRC_NONE   = 3'd0;
   localparam logic [2:0] SRC_DEVICE = 3'd1;
   localparam logic [2:0] SRC_CONFIG = 3'd2;
   localparam logic [2:0] SRC_STR0   = 3'd3;
   localparam logic [2:0] SRC_CODING = 3'd7;

   localparam logic [55:0] CODING_DEFAULT = 56'h08_0000_0001_C200;

   localparam logic [7:0] CFG_ROM [67] = '{
      8'd9, 8'h02, 8'd67, 8'h00, 8'd2, 8'd1, 8'd0, 8'h80, 8'd50,
      8'd9, 8'h04, 8'd0, 8'd0, 8'd1, 8'h02, 8'h02, 8'h01, 8'd0,
      8'd5, 8'h24, 8'h00, 8'h10, 8'h01,
      8'd5, 8'h24, 8'h01, 8'h00, 8'd1,
      8'd4, 8'h24, 8'h02, 8'h02,
      8'd5, 8'h24, 8'h06, 8'd0, 8'd1,
      8'd7, 8'h05, 8'h81, 8'h03, 8'd8, 8'h00, 8'h10,
      8'd9, 8'h04, 8'd1, 8'd0, 8'd2, 8'h0A, 8'h00, 8'h00, 8'd0,
      8'd7, 8'h05, 8'h02, 8'h02, 8'd64, 8'h00, 8'h00,
      8'd7, 8'h05, 8'h82, 8'h02, 8'd64, 8'h00, 8'h00
   };

   localparam logic [7:0] DEV_ROM [18] = '{
      8'd18, 8'h01, 8'h00, 8'h02, 8'h02, 8'h00, 8'h00, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'h00, 8'h02, 8'd1, 8'd2, 8'd3, 8'd1
   };

   localparam logic [7:0] SRC_LEN [8] = '{8'd0, 8'd18, 8'd67, 8'd4, 8'd20, 8'd26, 8'd10, 8'd7};

   localparam logic [71:0] VENDOR_TEXT  = "USB-MAKER";
   localparam logic [95:0] PRODUCT_TEXT = "SERIAL + DFU";
   localparam logic [31:0] SERIAL_TEXT  = "0001";
   localparam logic [31:0] TOKEN_TEXT   = "DFU!";
   localparam logic [7:0]  BOOT_CHAR    = "R";

   typedef struct packed {
      logic [2:0]  cmd;
      logic [7:0]  request_type;
      logic [7:0]  request_code;
      logic [15:0] request_value;
      logic [15:0] request_length;
      logic [9:0]  out_count;
      logic [55:0] line_coding_in;
      logic [7:0]  stream_byte;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] tx_byte;
      logic       last;
      logic [6:0] device_address;
      logic       boot_request;
   } rsp_payload_type;

   function automatic logic [7:0] text_byte(logic [1:0] sel, logic [6:0] off);
      logic [6:0] idx;
      logic [6:0] n;
      logic [7:0] ch;
      idx = 7'((off - 7'd2) >> 1);
      case (sel)
         2'd0: n = 7'd9;
         2'd1: n = 7'd12;
         default: n = 7'd4;
      endcase
      case (sel)
         2'd0: ch = VENDOR_TEXT[8 * (8 - 32'(idx[3:0])) +: 8];
         2'd1: ch = PRODUCT_TEXT[8 * (11 - 32'(idx[3:0])) +: 8];
         default: ch = SERIAL_TEXT[8 * (3 - 32'(idx[1:0])) +: 8];
      endcase
      if (off == 7'd0) begin
         return 8'(2 + 2 * n);
      end else if (off == 7'd1) begin
         return 8'h03;
      end else if (off[0] || idx >= n) begin
         return 8'h00;
      end
      return ch;
   endfunction

   function automatic logic [7:0] rom_byte(logic [2:0] src, logic [6:0] off,
                                          logic [15:0] vid, logic [15:0] pid,
                                          logic [55:0] coding);
      case (src)
         SRC_DEVICE: begin
            if (off >= 7'd18) return 8'h00;
            if (off == 7'd7) return 8'(MAX_PACKET);
            if (off == 7'd8) return vid[7:0];
            if (off == 7'd9) return vid[15:8];
            if (off == 7'd10) return pid[7:0];
            if (off == 7'd11) return pid[15:8];
            return DEV_ROM[off[4:0]];
         end
         SRC_CONFIG: return (off < 7'd67) ? CFG_ROM[off] : 8'h00;
         3'd3: begin
            case (off)
               7'd0: return 8'd4;
               7'd1: return 8'h03;
               7'd2: return 8'h09;
               7'd3: return 8'h04;
               default: return 8'h00;
            endcase
         end
         3'd4: return text_byte(2'd0, off);
         3'd5: return text_byte(2'd1, off);
         3'd6: return text_byte(2'd2, off);
         SRC_CODING: return (off < 7'd7) ? coding[8 * 32'(off[2:0]) +: 8] : 8'h00;
         default: return 8'h00;
      endcase
   endfunction

endpackage

// ----- hw/rtl/usb_cdc_control_responder_unit.sv -----
// The first result of an accepted transaction is registered from the S_FIX0 or S_DATA
// state that the accept enters, once the output slot is free. Throughput: one result
// per cycle while rsp_ready keeps the output free; a full packet holds up to 64 bytes.
// The block takes no new item until all results of the current one are sent.
// Reset is synchronous: it restores the register defaults and 115200 8N1.
// ----------------------------------------------------------------------------
// usb_cdc_control_responder_unit
// Endpoint-0 responder for a CDC-ACM device: decodes each bus event and
// emits its replies one result per cycle, unless rsp_ready stalls it, through a registered output.
// ----------------------------------------------------------------------------
module usb_cdc_control_responder_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  ucdc_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output ucdc_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [21:0]               csr_wdata
);
   import ucdc_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_FIX0, S_FIX1, S_DATA} state_type;

   state_type       state_ff;
   logic [15:0]     vid_ff, pid_ff;
   logic [21:0]     touch_ff;
   logic [6:0]      rem_ff, off_ff, apend_ff, cnt_ff, n_ff;
   logic [2:0]      src_ff;
   logic            await_ff, boot_ff, small_ff, b0_ff, two_ff;
   logic [55:0]     coding_ff;
   logic [1:0]      prog_ff;
   logic [2:0]      act0_ff, act1_ff;
   logic [6:0]      addr_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff;

   logic [6:0]  rem_in, off_in, apend_in, n_in;
   logic [2:0]  src_in, act0_in, act1_in;
   logic        await_in, boot_in, small_in, b0_in, two_in, data_in;
   logic [55:0] coding_in;
   logic [1:0]  prog_in;
   logic [6:0]  addr_in;
   logic [6:0]  len;
   logic [7:0]  dtype, didx;
   logic        accept, slot_free;
   logic [7:0]  byte_sel;

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign dtype     = req_data.request_value[15:8];
   assign didx      = req_data.request_value[7:0];

   always_comb begin
      rem_in    = rem_ff;
      off_in    = off_ff;
      src_in    = src_ff;
      apend_in  = apend_ff;
      await_in  = await_ff;
      coding_in = coding_ff;
      boot_in   = boot_ff;
      prog_in   = prog_ff;
      act0_in   = ACT_NONE;
      act1_in   = ACT_ARM;
      two_in    = 1'b0;
      addr_in   = '0;
      data_in   = 1'b0;
      small_in  = 1'b0;
      b0_in     = 1'b0;
      len       = '0;
      case (req_data.cmd)
         CMD_BUS_RESET: begin
            rem_in   = '0;
            off_in   = '0;
            src_in   = SRC_NONE;
            apend_in = '0;
            await_in = 1'b0;
            act0_in  = ACT_ADDR;
         end
         CMD_SETUP: begin
            await_in = 1'b0;
            rem_in   = '0;
            off_in   = '0;
            src_in   = SRC_NONE;
            act0_in  = ACT_STALL;
            if (req_data.request_type[6:5] == KIND_STANDARD) begin
               case (req_data.request_code)
                  REQ_GET_DESC: begin
                     if (dtype == 8'd1) begin
                        src_in = SRC_DEVICE;
                        data_in = 1'b1;
                     end else if (dtype == 8'd2) begin
                        src_in = SRC_CONFIG;
                        data_in = 1'b1;
                     end else if (dtype == 8'd3 && didx <= 8'd3) begin
                        src_in = 3'(SRC_STR0 + didx[2:0]);
                        data_in = 1'b1;
                     end
                  end
                  REQ_SET_ADDRESS: begin
                     apend_in = req_data.request_value[6:0];
                     act0_in  = ACT_ZLP;
                  end
                  REQ_SET_CONFIG: begin
                     if (req_data.request_value != 16'd0) begin
                        act0_in = ACT_ENABLE;
                        act1_in = ACT_ZLP;
                        two_in  = 1'b1;
                     end else begin
                        act0_in = ACT_ZLP;
                     end
                  end
                  REQ_GET_CONFIG: begin
                     small_in = 1'b1;
                     b0_in    = 1'b1;
                     len      = 7'd1;
                  end
                  REQ_GET_STATUS: begin
                     small_in = 1'b1;
                     len      = 7'd2;
                  end
                  REQ_GET_IFACE: begin
                     small_in = 1'b1;
                     len      = 7'd1;
                  end
                  REQ_CLEAR_FEATURE, REQ_SET_IFACE: act0_in = ACT_ZLP;
                  default: act0_in = ACT_STALL;
               endcase
            end else if (req_data.request_type[6:5] == KIND_CLASS) begin
               case (req_data.request_code)
                  REQ_SET_CODING: begin
                     await_in = 1'b1;
                     act0_in  = ACT_ARM;
                  end
                  REQ_GET_CODING: begin
                     src_in  = SRC_CODING;
                     data_in = 1'b1;
                  end
                  REQ_LINE_STATE: begin
                     if (!req_data.request_value[0] &&
                         coding_ff[31:0] == {10'd0, touch_ff}) begin
                        boot_in = 1'b1;
                     end
                     act0_in = ACT_ZLP;
                  end
                  REQ_SEND_BREAK: act0_in = ACT_ZLP;
                  default: act0_in = ACT_STALL;
               endcase
            end
            if (data_in) begin
               len = SRC_LEN[src_in][6:0];
               off_in = '0;
               rem_in = (req_data.request_length < {9'd0, len}) ?
                        req_data.request_length[6:0] : len;
            end else if (small_in) begin
               rem_in = '0;
               if (req_data.request_length < {9'd0, len}) begin
                  len = req_data.request_length[6:0];
               end
            end
         end
         CMD_OUT_DATA: begin
            act0_in = ACT_ARM;
            if (await_ff && req_data.out_count >= 10'd7) begin
               coding_in = req_data.line_coding_in;
               await_in  = 1'b0;
               act0_in   = ACT_ZLP;
               two_in    = 1'b1;
            end
         end
         CMD_IN_DONE: begin
            act0_in = ACT_ARM;
            if (rem_ff != '0) begin
               data_in = 1'b1;
            end else if (apend_ff != '0) begin
               act0_in  = ACT_ADDR;
               addr_in  = apend_ff;
               two_in   = 1'b1;
               apend_in = '0;
            end
         end
         CMD_DATA_BYTE: begin
            if (req_data.stream_byte == BOOT_CHAR) begin
               boot_in = 1'b1;
            end else if (req_data.stream_byte == TOKEN_TEXT[8 * (3 - 32'(prog_ff)) +: 8]) begin
               if (prog_ff == 2'd3) begin
                  prog_in = 2'd0;
                  boot_in = 1'b1;
               end else begin
                  prog_in = 2'(prog_ff + 2'd1);
               end
            end else begin
               prog_in = (req_data.stream_byte == TOKEN_TEXT[31:24]) ? 2'd1 : 2'd0;
            end
         end
         default: act0_in = ACT_NONE;
      endcase
      if (small_in) begin
         n_in = len;
         if (len == '0) begin
            small_in = 1'b0;
            act0_in  = ACT_ZLP;
         end
      end else begin
         n_in = (rem_in >= 7'(MAX_PACKET)) ? 7'(MAX_PACKET) : rem_in;
         if (data_in && n_in == '0) begin
            data_in = 1'b0;
            act0_in = ACT_ZLP;
         end
      end
   end

   always_comb begin
      if (small_ff) begin
         byte_sel = (cnt_ff == '0 && b0_ff) ? 8'd1 : 8'd0;
      end else begin
         byte_sel = rom_byte(src_ff, off_ff, vid_ff, pid_ff, coding_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vid_ff       <= 16'd1155;
         pid_ff       <= 16'd22336;
         touch_ff     <= 22'd1200;
         rem_ff       <= '0;
         off_ff       <= '0;
         src_ff       <= SRC_NONE;
         apend_ff     <= '0;
         await_ff     <= 1'b0;
         coding_ff    <= CODING_DEFAULT;
         boot_ff      <= 1'b0;
         prog_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_VENDOR_ID:  vid_ff   <= csr_wdata[15:0];
               REG_PRODUCT_ID: pid_ff   <= csr_wdata[15:0];
               REG_TOUCH_BAUD: touch_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  rem_ff    <= rem_in;
                  off_ff    <= off_in;
                  src_ff    <= src_in;
                  apend_ff  <= apend_in;
                  await_ff  <= await_in;
                  coding_ff <= coding_in;
                  boot_ff   <= boot_in;
                  prog_ff   <= prog_in;
                  act0_ff   <= act0_in;
                  act1_ff   <= act1_in;
                  two_ff    <= two_in;
                  addr_ff   <= addr_in;
                  small_ff  <= small_in;
                  b0_ff     <= b0_in;
                  n_ff      <= n_in;
                  cnt_ff    <= '0;
                  state_ff  <= (data_in || small_in) ? S_DATA : S_FIX0;
               end
            end
            S_FIX0: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= '{action: act0_ff, tx_byte: 8'd0, last: !two_ff,
                                    device_address: addr_ff, boot_request: boot_ff};
                  state_ff     <= two_ff ? S_FIX1 : S_IDLE;
               end
            end
            S_FIX1: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= '{action: act1_ff, tx_byte: 8'd0, last: 1'b1,
                                    device_address: 7'd0, boot_request: boot_ff};
                  state_ff     <= S_IDLE;
               end
            end
            S_DATA: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= '{action: ACT_DATA, tx_byte: byte_sel,
                                    last: (cnt_ff == 7'(n_ff - 7'd1)),
                                    device_address: 7'd0, boot_request: boot_ff};
                  cnt_ff       <= 7'(cnt_ff + 7'd1);
                  if (!small_ff) begin
                     off_ff <= 7'(off_ff + 7'd1);
                     rem_ff <= 7'(rem_ff - 7'd1);
                  end
                  if (cnt_ff == 7'(n_ff - 7'd1)) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ----- hw/rtl/ucdc_checker.sv -----
// ----------------------------------------------------------------------------
// ucdc_checker
// Port-level checks of the CDC-ACM control responder, bound to the responder module.
// ----------------------------------------------------------------------------
module ucdc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input ucdc_pkg::rsp_payload_type rsp_data
);
   import ucdc_pkg::*;

   // A result that is not taken must be held unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // The bootloader request does not fall on a result that directly follows one that raised it.
   a_boot_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.boot_request |=> !rsp_valid || rsp_data.boot_request)
      else $error("boot request dropped");

   // Once a transaction is accepted, req_ready must fall, so no second one is taken while busy.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new transaction taken while busy");

   // Only data results carry a byte, and only address results an address.
   a_clean_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.action == ACT_DATA || rsp_data.tx_byte == 8'd0) &&
                    (rsp_data.action == ACT_ADDR || rsp_data.device_address == 7'd0))
      else $error("stray payload field");

endmodule

bind usb_cdc_control_responder_unit ucdc_checker u_ucdc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CDC-ACM control responder: a queue-fed driver
// offers bus events with random gaps, a behavioural predictor works out the
// replies of each accepted transaction, and a monitor with random back-pressure
// compares every reply field by field. Registers are changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
   import ucdc_pkg::*;

   localparam logic [2:0] CMD_SPARE_LOW  = 3'd5;
   localparam logic [2:0] CMD_SPARE_HIGH = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [21:0] csr_wdata = '0;

   usb_cdc_control_responder_unit dut (.*);

   always #5 clock = ~clock;

   req_payload_type pending_events[$];
   rsp_payload_type expected_replies[$];
   int error_count = 0;
   int hold_cycles = 0;
   int stall_count = 0;
   int idle_cycles = 0;
   int gap_count = 0;
   logic [15:0] vid_model = 16'd1155;
   logic [15:0] pid_model = 16'd22336;
   logic [21:0] touch_model = 22'd1200;
   logic [6:0] remaining_model, offset_model, addr_model;
   logic [2:0] source_model;
   logic coding_wait_model, boot_model;
   logic [1:0] token_model;
   logic [55:0] coding_model = CODING_DEFAULT;
   rsp_payload_type burst[$];

   task automatic report(string what, rsp_payload_type got, rsp_payload_type want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   function automatic logic [7:0] string_byte(string s, int off);
      if (off == 0) return 8'(2 + 2 * s.len());
      if (off == 1) return 8'h03;
      if (off[0] || (off - 2) / 2 >= s.len()) return 8'h00;
      return s[(off - 2) / 2];
   endfunction

   function automatic logic [7:0] descriptor_byte(logic [2:0] src, int off);
      logic [7:0] dev[18];
      logic [7:0] cfg[67];
      dev = '{18, 1, 0, 2, 2, 0, 0, 0, 0, 0, 0, 0, 0, 2, 1, 2, 3, 1};
      cfg = '{9, 2, 67, 0, 2, 1, 0, 8'h80, 50, 9, 4, 0, 0, 1, 2, 2, 1, 0,
              5, 8'h24, 0, 8'h10, 1, 5, 8'h24, 1, 0, 1, 4, 8'h24, 2, 2,
              5, 8'h24, 6, 0, 1, 7, 5, 8'h81, 3, 8, 0, 8'h10,
              9, 4, 1, 0, 2, 8'h0A, 0, 0, 0, 7, 5, 2, 2, 64, 0, 0,
              7, 5, 8'h82, 2, 64, 0, 0};
      case (src)
         SRC_DEVICE: begin
            if (off >= 18) return 8'h00;
            if (off == 7) return 8'd64;
            if (off == 8) return vid_model[7:0];
            if (off == 9) return vid_model[15:8];
            if (off == 10) return pid_model[7:0];
            if (off == 11) return pid_model[15:8];
            return dev[off];
         end
         SRC_CONFIG: return off < 67 ? cfg[off] : 8'h00;
         3'd3: return off == 0 ? 8'd4 : off == 1 ? 8'h03 : off == 2 ? 8'h09 :
                      off == 3 ? 8'h04 : 8'h00;
         3'd4: return string_byte("USB-MAKER", off);
         3'd5: return string_byte("SERIAL + DFU", off);
         3'd6: return string_byte("0001", off);
         SRC_CODING: return off < 7 ? coding_model[8 * off +: 8] : 8'h00;
         default: return 8'h00;
      endcase
   endfunction

   function automatic void emit(logic [2:0] act, logic [7:0] b, logic [6:0] a);
      rsp_payload_type r;
      r = '0;
      r.action = act;
      r.tx_byte = b;
      r.device_address = a;
      burst.push_back(r);
   endfunction

   function automatic void send_packet();
      int n;
      n = remaining_model < 64 ? remaining_model : 64;
      if (n == 0) begin
         emit(ACT_ZLP, 0, 0);
         return;
      end
      for (int i = 0; i < n; i++)
         emit(ACT_DATA, descriptor_byte(source_model, offset_model + i), 0);
      offset_model = 7'(offset_model + n);
      remaining_model = 7'(remaining_model - n);
   endfunction

   function automatic void begin_reply(logic [2:0] src, logic [15:0] want);
      int len;
      len = (src == SRC_DEVICE) ? 18 : (src == SRC_CONFIG) ? 67 : (src == 3'd3) ? 4 :
            (src == 3'd4) ? 20 : (src == 3'd5) ? 26 : (src == 3'd6) ? 10 : 7;
      source_model = src;
      offset_model = 0;
      remaining_model = 7'(len < want ? len : want);
      send_packet();
   endfunction

   function automatic void short_reply(logic [7:0] b0, int len, logic [15:0] want);
      int n;
      n = len < want ? len : want;
      if (n == 0) emit(ACT_ZLP, 0, 0);
      for (int i = 0; i < n; i++) emit(ACT_DATA, i == 0 ? b0 : 8'h00, 0);
   endfunction

   function automatic void predict_event(req_payload_type q);
      logic [7:0] dtype, didx, c;
      dtype = q.request_value[15:8];
      didx = q.request_value[7:0];
      burst.delete();
      case (q.cmd)
         CMD_BUS_RESET: begin
            remaining_model = 0; source_model = 0; offset_model = 0;
            addr_model = 0; coding_wait_model = 0;
            emit(ACT_ADDR, 0, 0);
         end
         CMD_SETUP: begin
            coding_wait_model = 0;
            remaining_model = 0; source_model = 0; offset_model = 0;
            if (q.request_type[6:5] == KIND_STANDARD) begin
               case (q.request_code)
                  REQ_GET_DESC:
                     if (dtype == 1) begin_reply(SRC_DEVICE, q.request_length);
                     else if (dtype == 2) begin_reply(SRC_CONFIG, q.request_length);
                     else if (dtype == 3 && didx <= 3)
                        begin_reply(3'(3 + didx), q.request_length);
                     else emit(ACT_STALL, 0, 0);
                  REQ_SET_ADDRESS: begin
                     addr_model = q.request_value[6:0];
                     emit(ACT_ZLP, 0, 0);
                  end
                  REQ_SET_CONFIG: begin
                     if (q.request_value != 0) emit(ACT_ENABLE, 0, 0);
                     emit(ACT_ZLP, 0, 0);
                  end
                  REQ_GET_CONFIG: short_reply(1, 1, q.request_length);
                  REQ_GET_STATUS: short_reply(0, 2, q.request_length);
                  REQ_GET_IFACE: short_reply(0, 1, q.request_length);
                  REQ_CLEAR_FEATURE, REQ_SET_IFACE: emit(ACT_ZLP, 0, 0);
                  default: emit(ACT_STALL, 0, 0);
               endcase
            end else if (q.request_type[6:5] == KIND_CLASS) begin
               case (q.request_code)
                  REQ_SET_CODING: begin
                     coding_wait_model = 1;
                     emit(ACT_ARM, 0, 0);
                  end
                  REQ_GET_CODING: begin_reply(SRC_CODING, q.request_length);
                  REQ_LINE_STATE: begin
                     if (!q.request_value[0] && coding_model[31:0] == 32'(touch_model))
                        boot_model = 1;
                     emit(ACT_ZLP, 0, 0);
                  end
                  REQ_SEND_BREAK: emit(ACT_ZLP, 0, 0);
                  default: emit(ACT_STALL, 0, 0);
               endcase
            end else emit(ACT_STALL, 0, 0);
         end
         CMD_OUT_DATA: begin
            if (coding_wait_model && q.out_count >= 7) begin
               coding_model = q.line_coding_in;
               coding_wait_model = 0;
               emit(ACT_ZLP, 0, 0);
            end
            emit(ACT_ARM, 0, 0);
         end
         CMD_IN_DONE:
            if (remaining_model > 0) send_packet();
            else begin
               if (addr_model != 0) begin
                  emit(ACT_ADDR, 0, addr_model);
                  addr_model = 0;
               end
               emit(ACT_ARM, 0, 0);
            end
         CMD_DATA_BYTE: begin
            c = q.stream_byte;
            if (c == BOOT_CHAR) boot_model = 1;
            else if (c == TOKEN_TEXT[8 * (3 - token_model) +: 8]) begin
               token_model = token_model + 1;
               if (token_model == 0) boot_model = 1;
            end else token_model = (c == TOKEN_TEXT[31:24]) ? 2'd1 : 2'd0;
            emit(ACT_NONE, 0, 0);
         end
         default: emit(ACT_NONE, 0, 0);
      endcase
      foreach (burst[i]) begin
         burst[i].boot_request = boot_model;
         burst[i].last = (i == burst.size() - 1);
         expected_replies.push_back(burst[i]);
      end
   endfunction

   // Driver: one transaction at a time, with a random, possibly empty gap before each.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_ready) begin
         predict_event(req_data);
         if (pending_events.size() > 0 && gap_count == 0 && $urandom_range(1, 0) == 1) begin
            req_data <= pending_events.pop_front();
         end else begin
            req_valid <= 1'b0;
            gap_count <= $urandom_range(12, 0);
         end
      end else if (!req_valid && pending_events.size() > 0) begin
         if (gap_count > 0) begin
            gap_count <= gap_count - 1;
         end else begin
            req_valid <= 1'b1;
            req_data <= pending_events.pop_front();
         end
      end
   end

   // Monitor with random stalls and an occasional long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               report("unexpected reply", rsp_data, '0);
            end else if (rsp_data !== expected_replies[0]) begin
               report("reply field", rsp_data, expected_replies[0]);
               void'(expected_replies.pop_front());
            end else begin
               void'(expected_replies.pop_front());
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_ready <= 1'b0;
         end else if (rsp_valid && rsp_ready) begin
            stall_count = $urandom_range(2, 0) == 0 ? $urandom_range(12, 0) : 0;
            rsp_ready <= (stall_count == 0);
            if (stall_count > 0) hold_cycles <= stall_count - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 3000) begin
         $display("usb_cdc_control_responder_unit test failed");
         $finish;
      end
   end

   function automatic req_payload_type make_event(logic [2:0] cmd, logic [7:0] rtype,
                                                  logic [7:0] code, logic [15:0] val,
                                                  logic [15:0] len);
      req_payload_type q;
      q.cmd = cmd;
      q.request_type = rtype;
      q.request_code = code;
      q.request_value = val;
      q.request_length = len;
      q.out_count = 10'($urandom);
      q.line_coding_in = 56'({$urandom, $urandom});
      q.stream_byte = 8'($urandom);
      return q;
   endfunction

   function automatic req_payload_type random_event();
      req_payload_type q;
      logic [7:0] codes[12];
      logic [39:0] byte_picks;
      int pick;
      codes = '{REQ_GET_STATUS, REQ_CLEAR_FEATURE, REQ_SET_ADDRESS, REQ_GET_DESC,
                REQ_GET_CONFIG, REQ_SET_CONFIG, REQ_GET_IFACE, REQ_SET_IFACE,
                REQ_SET_CODING, REQ_GET_CODING, REQ_LINE_STATE, REQ_SEND_BREAK};
      byte_picks = "DFU!R";
      q = make_event(3'($urandom_range(7, 0)), 8'($urandom), 8'($urandom),
                     16'($urandom), 16'($urandom));
      pick = $urandom_range(9, 0);
      if (pick < 5) begin
         q.cmd = CMD_SETUP;
         q.request_type = {q.request_type[7], $urandom_range(5, 0) == 0 ? 2'd1 : 2'd0,
                           q.request_type[4:0]};
         if ($urandom_range(3, 0) != 0) q.request_code = codes[$urandom_range(11, 0)];
         if (q.request_code == REQ_SET_CODING || q.request_code == REQ_GET_CODING ||
             q.request_code == REQ_LINE_STATE || q.request_code == REQ_SEND_BREAK)
            q.request_type[6:5] = 2'd1;
         if (q.request_code == REQ_GET_DESC && $urandom_range(3, 0) != 0)
            q.request_value = {8'($urandom_range(3, 1)), 8'($urandom_range(4, 0))};
         if ($urandom_range(2, 0) != 0) q.request_length = 16'($urandom_range(200, 0));
      end else if (pick < 7) begin
         q.cmd = CMD_IN_DONE;
      end else if (pick == 7) begin
         q.cmd = CMD_OUT_DATA;
         if ($urandom_range(2, 0) == 0) q.line_coding_in[31:0] = 32'(touch_model);
         if ($urandom_range(3, 0) != 0) q.out_count = 10'($urandom_range(9, 5));
      end else if (pick == 8) begin
         q.cmd = CMD_DATA_BYTE;
         if ($urandom_range(1, 0) == 1)
            q.stream_byte = byte_picks[8 * int'($urandom_range(4, 0)) +: 8];
      end
      return q;
   endfunction

   task automatic settle_and_write(logic [1:0] idx, logic [21:0] value);
      while (pending_events.size() > 0 || req_valid || expected_replies.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_VENDOR_ID) vid_model = value[15:0];
      else if (idx == REG_PRODUCT_ID) pid_model = value[15:0];
      else touch_model = value;
   endtask

   initial begin
      remaining_model = 0; offset_model = 0; addr_model = 0; source_model = 0;
      coding_wait_model = 0; boot_model = 0; token_model = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      pending_events.push_back(make_event(CMD_SETUP, 8'h80, REQ_GET_DESC, 16'h0100, 16'hFFFF));
      pending_events.push_back(make_event(CMD_SETUP, 8'h80, REQ_GET_DESC, 16'h0200, 16'hFFFF));
      pending_events.push_back(make_event(CMD_IN_DONE, '0, '0, '0, '0));
      pending_events.push_back(make_event(CMD_IN_DONE, '0, '0, '0, '0));
      pending_events.push_back(make_event(CMD_SETUP, 8'h80, REQ_GET_DESC, 16'h0200, 16'd64));
      pending_events.push_back(make_event(CMD_IN_DONE, '0, '0, '0, '0));
      for (int i = 0; i < 5; i++)
         pending_events.push_back(make_event(CMD_SETUP, 8'h80, REQ_GET_DESC,
                                             16'(16'h0300 + i), 16'd255));
      pending_events.push_back(make_event(CMD_SETUP, 8'h80, REQ_GET_DESC, 16'h0700, 16'd9));
      pending_events.push_back(make_event(CMD_SETUP, 8'h80, REQ_GET_DESC, 16'h0100, 16'd0));
      pending_events.push_back(make_event(CMD_SETUP, 8'h00, REQ_SET_ADDRESS, 16'h007F, '0));
      pending_events.push_back(make_event(CMD_IN_DONE, '0, '0, '0, '0));
      pending_events.push_back(make_event(CMD_SETUP, 8'h00, REQ_SET_CONFIG, 16'd0, '0));
      pending_events.push_back(make_event(CMD_SETUP, 8'h00, REQ_SET_CONFIG, 16'd1, '0));
      pending_events.push_back(make_event(CMD_SETUP, 8'hE0, REQ_GET_STATUS, '0, 16'd2));
      pending_events.push_back(make_event(CMD_SETUP, 8'hC0, REQ_GET_STATUS, '0, 16'd2));
      pending_events.push_back(make_event(CMD_SETUP, 8'h21, REQ_SET_CODING, '0, 16'd7));
      pending_events[$].out_count = 10'h3FF;
      pending_events.push_back(make_event(CMD_OUT_DATA, '0, '0, '0, '0));
      pending_events[$].out_count = 10'h3FF;
      pending_events[$].line_coding_in = 56'h08_0000_0000_04B0;
      pending_events.push_back(make_event(CMD_SETUP, 8'hA1, REQ_GET_CODING, '0, 16'd7));
      pending_events.push_back(make_event(CMD_SETUP, 8'h21, REQ_LINE_STATE, 16'd0, '0));
      pending_events.push_back(make_event(CMD_BUS_RESET, '0, '0, '0, '0));
      pending_events.push_back(make_event(CMD_SPARE_LOW, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
      pending_events.push_back(make_event(CMD_SPARE_HIGH, '0, '0, '0, '0));
      // The receiver holds off while the sender keeps offering transactions.
      for (int i = 0; i < 8; i++)
         pending_events.push_back(make_event(CMD_SETUP, 8'h80, REQ_GET_DESC, 16'h0200, 16'd40));
      hold_cycles = 400;
      settle_and_write(REG_VENDOR_ID, 22'hFFFF);
      settle_and_write(REG_PRODUCT_ID, 22'h0000);
      settle_and_write(REG_TOUCH_BAUD, 22'd4000000);
      for (int phase = 0; phase < 4; phase++) begin
         for (int i = 0; i < 84; i++) pending_events.push_back(random_event());
         settle_and_write(REG_VENDOR_ID, 22'($urandom));
         settle_and_write(REG_PRODUCT_ID, phase == 1 ? 22'hFFFF : 22'($urandom));
         settle_and_write(REG_TOUCH_BAUD, phase == 0 ? 22'd0 :
                          phase == 1 ? 22'h3FFFFF : 22'($urandom_range(4000000, 0)));
      end
      while (pending_events.size() > 0 || req_valid || expected_replies.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) $display("usb_cdc_control_responder_unit test passed");
      else $display("usb_cdc_control_responder_unit test failed");
      $finish;
   end
endmodule
